@@ hw/rtl/kmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Matrix geometry, field widths, the result record and a bit count helper.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROWS = 9;
    localparam int COLS = 20;

    localparam int ROW_FIELD_W = 4;
    localparam int PIN_FIELD_W = 20;
    localparam int RELOAD_W    = 8;
    localparam int COUNT_OUT_W = 8;

    localparam int IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POP_W   = $clog2(COLS + 1);
    localparam int CNT_W   = $clog2(ROWS * COLS + 1);
    localparam int TOT_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    localparam logic [RELOAD_W-1:0] RELOAD_AT_RESET = RELOAD_W'(5);
    localparam logic [TOT_W-1:0]    COUNT_SAT       = TOT_W'(255);

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] key_count;
        logic                   settled;
        logic [PIN_FIELD_W-1:0] stable_row;
    } t_result;

    function automatic logic [POP_W-1:0] pop_count(input logic [COLS-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < COLS; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [TOT_W-1:0] t);
        return (t > COUNT_SAT) ? {COUNT_OUT_W{1'b1}} : t[COUNT_OUT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/kmd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce core
// Raw and stable matrices, the global debounce counter and running key counts.
// ----------------------------------------------------------------------------
module kmd_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [kmd_pkg::ROW_FIELD_W-1:0] i_row,
    input  logic [kmd_pkg::PIN_FIELD_W-1:0] i_pins,
    input  logic                            i_last,
    input  logic                            i_cfg_we,
    input  logic [kmd_pkg::RELOAD_W-1:0]    i_cfg_data,
    output kmd_pkg::t_result                o_result
);
    import kmd_pkg::*;

    logic [COLS-1:0]     r_raw [ROWS];
    logic [COLS-1:0]     r_stable [ROWS];
    logic [RELOAD_W-1:0] r_reload;
    logic [RELOAD_W-1:0] r_cnt;
    logic [TOT_W-1:0]    r_raw_total;
    logic [TOT_W-1:0]    r_stable_total;

    logic                row_ok;
    logic [IDX_W-1:0]    idx;
    logic [COLS-1:0]     pressed;
    logic [COLS-1:0]     old_raw;
    logic                changed;
    logic [RELOAD_W-1:0] cnt_mid;
    logic                dec;
    logic [RELOAD_W-1:0] n_cnt;
    logic                copy;
    logic [TOT_W-1:0]    n_raw_total;
    logic [COLS-1:0]     row_after;

    always_comb begin
        row_ok      = 32'(i_row) < 32'(ROWS);
        idx         = i_row[IDX_W-1:0];
        pressed     = ~i_pins[COLS-1:0];
        old_raw     = row_ok ? r_raw[idx] : '0;
        changed     = row_ok && (old_raw != pressed);
        cnt_mid     = changed ? r_reload : r_cnt;
        dec         = i_last && (cnt_mid != '0);
        n_cnt       = dec ? cnt_mid - RELOAD_W'(1) : cnt_mid;
        copy        = dec && (n_cnt == '0);
        n_raw_total = changed ? r_raw_total - TOT_W'(pop_count(old_raw))
                                + TOT_W'(pop_count(pressed))
                              : r_raw_total;
        row_after   = changed ? pressed : old_raw;

        o_result.stable_row = '0;
        if (row_ok) begin
            o_result.stable_row = PIN_FIELD_W'(copy ? row_after : r_stable[idx]);
        end
        o_result.settled   = (n_cnt == '0);
        o_result.key_count = sat_count(copy ? n_raw_total : r_stable_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload       <= RELOAD_AT_RESET;
            r_cnt          <= RELOAD_AT_RESET;
            r_raw_total    <= '0;
            r_stable_total <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_raw[r]    <= '0;
                r_stable[r] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_reload <= i_cfg_data;
            end
            if (i_fire) begin
                r_cnt       <= n_cnt;
                r_raw_total <= n_raw_total;
                if (changed) begin
                    r_raw[idx] <= pressed;
                end
                if (copy) begin
                    r_stable_total <= n_raw_total;
                    for (int r = 0; r < ROWS; r++) begin
                        r_stable[r] <= (changed && (idx == IDX_W'(r))) ? pressed : r_raw[r];
                    end
                end
            end
        end
    end

endmodule

@@ hw/rtl/kmd_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce output buffer
// Output register and a skid stage; input side waits only while skid is full.
// ----------------------------------------------------------------------------
module kmd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  kmd_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output kmd_pkg::t_result o_data
);
    import kmd_pkg::*;

    logic    r_out_valid;
    t_result r_out_data;
    logic    r_skid_valid;
    t_result r_skid_data;
    logic    fire;

    assign o_ready = !r_skid_valid;
    assign fire    = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= fire;
            end
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (fire) begin
            r_skid_data <= i_data;
        end
    end

endmodule

@@ hw/rtl/key_matrix_debounce_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce unit
// Debounces a scanned key matrix with one global counter and reports keys.
// ----------------------------------------------------------------------------
// The scan driver sends one row sample per transaction on the s_axis channel:
// the active-low column pins in tdata, the row number in tuser and the end of
// a scan pass in tlast. Each sample yields exactly one transaction on the
// m_axis channel with the debounced row, the key count over the whole stable
// matrix and, in tuser, a flag that is set while the matrix is settled.
// A result is registered as its sample is taken; a sample can be taken every
// cycle while s_axis_tready is high, and all state is updated in the cycle of
// acceptance. When the receiver stalls, one further result is held in a skid
// stage; s_axis_tready drops only while both the output and skid registers
// are full. The cfg channel writes the reload value of the debounce counter;
// it is always ready and should be written only while no transaction is in
// flight. Reset clears both matrices and the key count, and sets the reload
// value and the counter to five scan passes.
// ----------------------------------------------------------------------------
module key_matrix_debounce_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] column_pins
    input  logic [3:0]  s_axis_tuser,   // [3:0] row_index
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [19:0] stable_row, [27:20] key_count
    output logic        m_axis_tuser,   // [0] settled
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import kmd_pkg::*;

    t_result core_result;
    t_result out_result;
    logic    fire;

    assign fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    kmd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_row      (s_axis_tuser),
        .i_pins     (s_axis_tdata[PIN_FIELD_W-1:0]),
        .i_last     (s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (core_result)
    );

    kmd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (core_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    assign m_axis_tdata = {4'd0, out_result.key_count, out_result.stable_row};
    assign m_axis_tuser = out_result.settled;

endmodule
